### src/tsdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsdc_pkg: shared definitions for the threshold screen dot classifier
// Types, constants and small arithmetic helpers used by the pipeline modules.
// ----------------------------------------------------------------------------
package tsdc_pkg;

	// Cut point and swap band constants.
	localparam logic [7:0] SMALL_CUT_LOW  = 8'd64;
	localparam logic [7:0] MEDIUM_CUT_LOW = 8'd130;
	localparam logic [7:0] SWAP_LOW       = 8'd96;
	localparam logic [8:0] SWAP_HIGH      = 9'd160;
	localparam logic [7:0] THR_MAX        = 8'd254;
	localparam logic [7:0] FULL_TONE      = 8'd255;

	// Coordinate hash constants; the seed and the fixed term fold into one.
	localparam logic [31:0] HASH_MUL_X = 32'h85EBCA6B;
	localparam logic [31:0] HASH_MUL_Y = 32'hC2B2AE35;
	localparam logic [31:0] HASH_K     = 32'h27D4EB2D ^ 32'h51F2F90D;
	localparam logic [31:0] HASH_MUL_A = 32'h7FEB352D;
	localparam logic [31:0] HASH_MUL_B = 32'h846CA68B;

	// Pipeline depths.
	localparam int DIV_LAT    = 4;
	localparam int HASH_LAT   = 4;
	localparam int HASH_DELAY = 2 * DIV_LAT + 2 - HASH_LAT;

	// Dot levels.
	localparam logic [1:0] DOT_NONE   = 2'd0;
	localparam logic [1:0] DOT_SMALL  = 2'd1;
	localparam logic [1:0] DOT_MEDIUM = 2'd2;
	localparam logic [1:0] DOT_LARGE  = 2'd3;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_MIN_INK,
		REG_FLOOR_RANGE,
		REG_FLOOR_MAX,
		REG_SMALL_BASE,
		REG_MEDIUM_BASE,
		REG_SWAP_EN,
		REG_USE_EFF
	} reg_index_t;

	typedef struct packed {
		logic [7:0] min_ink;
		logic [7:0] floor_range;
		logic [7:0] floor_max;
		logic [7:0] small_base;
		logic [7:0] medium_base;
		logic       swap_en;
		logic       use_eff;
	} cfg_t;

	// Pixel data that rides along the divider stages.
	typedef struct packed {
		logic       below;
		logic [7:0] tone;
		logic [7:0] mask;
	} sb_t;

	// Pixel data that rides along the bias divider.
	typedef struct packed {
		sb_t        sb;
		logic [7:0] eff;
		logic       bias_en;
	} bias_sb_t;

	// Input of the classification stages.
	typedef struct packed {
		logic       valid;
		logic       below;
		logic [7:0] tone;
		logic [7:0] mask;
		logic [7:0] eff;
		logic       bias_en;
		logic [7:0] bias;
		logic [7:0] hash;
	} cls_in_t;

	// One stage of the restoring divider.
	typedef struct packed {
		logic [7:0] rem;
		logic [7:0] nlo;
		logic [7:0] den;
		logic [7:0] quo;
	} div_stage_t;

	// Two restoring division steps; the partial remainder stays below den.
	function automatic div_stage_t div_two(input div_stage_t s);
		div_stage_t o;
		logic [8:0] t;
		o = s;
		for (int i = 0; i < 2; i++) begin
			t = {o.rem, o.nlo[7]};
			o.nlo = {o.nlo[6:0], 1'b0};
			if (t >= {1'b0, o.den}) begin
				t = t - {1'b0, o.den};
				o.quo = {o.quo[6:0], 1'b1};
			end else begin
				o.quo = {o.quo[6:0], 1'b0};
			end
			o.rem = t[7:0];
		end
		return o;
	endfunction

	// Exact floor(x / 255) for x up to 255 * 255.
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] s;
		s = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
		return s[15:8];
	endfunction

endpackage

### src/tsdc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsdc_div: pipelined 16 by 8 bit divider
// Restoring division, two quotient bits per stage; the quotient must fit in
// eight bits, that is the numerator is below 256 times the divisor.
// ----------------------------------------------------------------------------
module tsdc_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [15:0] num,
	input  logic [7:0]  den,
	output logic        out_valid,
	output logic [7:0]  quo
);

	logic [tsdc_pkg::DIV_LAT-1:0] vld_s;
	tsdc_pkg::div_stage_t         stg_s [tsdc_pkg::DIV_LAT];
	tsdc_pkg::div_stage_t         first;

	// The upper numerator byte is the starting remainder.
	always_comb begin
		first.rem = num[15:8];
		first.nlo = num[7:0];
		first.den = den;
		first.quo = '0;
	end

	// Valid bits travel with the stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[tsdc_pkg::DIV_LAT-2:0], in_valid};
		end
	end

	// Division stages.
	always_ff @(posedge clk) begin
		stg_s[0] <= tsdc_pkg::div_two(first);
		for (int i = 1; i < tsdc_pkg::DIV_LAT; i++) begin
			stg_s[i] <= tsdc_pkg::div_two(stg_s[i-1]);
		end
	end

	assign out_valid = vld_s[tsdc_pkg::DIV_LAT-1];
	assign quo       = stg_s[tsdc_pkg::DIV_LAT-1].quo;

endmodule

### src/tsdc_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsdc_hash: coordinate hash pipeline
// Mixes the pixel coordinates into a 32-bit hash over four stages and
// returns the XOR of its low byte and its third byte.
// ----------------------------------------------------------------------------
module tsdc_hash (
	input  logic        clk,
	input  logic [15:0] pixel_x,
	input  logic [15:0] pixel_y,
	output logic [7:0]  hash
);

	logic [31:0] h0;
	logic [31:0] mix_s1;
	logic [31:0] mul_s2;
	logic [31:0] mix2;
	logic [31:0] mul_s3;
	logic [7:0]  hash_s4;

	// Seed the hash from both coordinates.
	always_comb begin
		h0   = (32'(pixel_x) * tsdc_pkg::HASH_MUL_X) ^ (32'(pixel_y) * tsdc_pkg::HASH_MUL_Y)
		     ^ tsdc_pkg::HASH_K;
		mix2 = mul_s2 ^ (mul_s2 >> 15);
	end

	// Stage registers; the second and third stages each end in one multiplication.
	always_ff @(posedge clk) begin
		mix_s1  <= h0 ^ (h0 >> 16);
		mul_s2  <= mix_s1 * tsdc_pkg::HASH_MUL_A;
		mul_s3  <= mix2 * tsdc_pkg::HASH_MUL_B;
		hash_s4 <= mul_s3[7:0] ^ mul_s3[23:16];
	end

	assign hash = hash_s4;

endmodule

### src/tsdc_class.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsdc_class: dot classification stages
// Applies the floor bias, selects the class tone, interpolates the cut
// points, picks the dot level and applies the optional dot swap.
// ----------------------------------------------------------------------------
module tsdc_class (
	input  logic              clk,
	input  logic              arst_n,
	input  tsdc_pkg::cls_in_t cin,
	input  tsdc_pkg::cfg_t    cfg,
	output logic              done,
	output logic [1:0]        dot_level,
	output logic [7:0]        effective_tone
);

	logic [8:0]  eff_sum;
	logic [7:0]  eff2;

	logic        vld_s1, vld_s2;
	logic        below_s1, below_s2;
	logic        inked_s1, inked_s2;
	logic [7:0]  v_s1, v_s2;
	logic [7:0]  mask_s1;
	logic [7:0]  hash_s1;

	logic [7:0]  inv_v;
	logic [8:0]  band;
	logic [15:0] pnum;
	logic        swap;

	logic [15:0] rel_s2, scn_s2, mcn_s2;
	logic        swap_s2;

	logic [7:0]  rel, scut, mcut;
	logic [1:0]  lvl, lvl_sw;

	logic        done_q;
	logic [1:0]  level_q;
	logic [7:0]  tone_q;

	// Add the floor bias with saturation.
	always_comb begin
		eff_sum = {1'b0, cin.eff} + (cin.bias_en ? {1'b0, cin.bias} : 9'd0);
		eff2    = eff_sum[8] ? tsdc_pkg::FULL_TONE : eff_sum[7:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= cin.valid;
			vld_s2 <= vld_s1;
			done_q <= vld_s2;
		end
	end

	// Stage 1: class tone and inking decision.
	always_ff @(posedge clk) begin
		below_s1 <= cin.below;
		inked_s1 <= eff2 > cin.mask;
		v_s1     <= cfg.use_eff ? eff2 : cin.tone;
		mask_s1  <= cin.mask;
		hash_s1  <= cin.hash;
	end

	// Swap probability falls linearly across the transition band.
	always_comb begin
		inv_v = tsdc_pkg::FULL_TONE - v_s1;
		band  = tsdc_pkg::SWAP_HIGH - {1'b0, v_s1};
		pnum  = (16'(band[6:0]) << 8) - 16'(band[6:0]);
		swap  = cfg.swap_en && ((v_s1 < tsdc_pkg::SWAP_LOW) ||
		        (({1'b0, v_s1} < tsdc_pkg::SWAP_HIGH) && (hash_s1 < pnum[13:6])));
	end

	// Stage 2: products for the relative tone and the blended cut points.
	always_ff @(posedge clk) begin
		below_s2 <= below_s1;
		inked_s2 <= inked_s1;
		v_s2     <= v_s1;
		swap_s2  <= swap;
		rel_s2   <= 16'(mask_s1) * 16'(v_s1);
		scn_s2   <= 16'(inv_v) * 16'(tsdc_pkg::SMALL_CUT_LOW) + 16'(v_s1) * 16'(cfg.small_base);
		mcn_s2   <= 16'(inv_v) * 16'(tsdc_pkg::MEDIUM_CUT_LOW) + 16'(v_s1) * 16'(cfg.medium_base);
	end

	// Level from the cut points, then the mirror for the swap.
	always_comb begin
		rel  = tsdc_pkg::div255(rel_s2);
		scut = tsdc_pkg::div255(scn_s2);
		mcut = tsdc_pkg::div255(mcn_s2);
		priority if (rel <= scut) lvl = tsdc_pkg::DOT_SMALL;
		else if (rel <= mcut)     lvl = tsdc_pkg::DOT_MEDIUM;
		else                      lvl = tsdc_pkg::DOT_LARGE;
		lvl_sw = lvl;
		if (swap_s2) begin
			unique case (lvl)
				tsdc_pkg::DOT_SMALL: lvl_sw = tsdc_pkg::DOT_LARGE;
				tsdc_pkg::DOT_LARGE: lvl_sw = tsdc_pkg::DOT_SMALL;
				default:             lvl_sw = lvl;
			endcase
		end
	end

	// Stage 3: output register.
	always_ff @(posedge clk) begin
		level_q <= (below_s2 || !inked_s2) ? tsdc_pkg::DOT_NONE : lvl_sw;
		tone_q  <= below_s2 ? 8'd0 : v_s2;
	end

	assign done           = done_q;
	assign dot_level      = level_q;
	assign effective_tone = tone_q;

endmodule

### src/threshold_screen_dot_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// threshold_screen_dot_classifier: variable dot halftone classifier
// A pixel goes in on start; its dot level and effective tone come out
// with one pulse of done.
// ----------------------------------------------------------------------------
// Usage:
// - Drive tone, mask_value, pixel_x and pixel_y with start high. The transfer
//   happens at the clock edge where start is high and busy is low; busy
//   never rises, so a pixel can be accepted in every cycle.
// - Each result shows on dot_level and effective_tone for one cycle with
//   done high, in input order.
// - Throughput is one pixel per cycle. The latency is set by two divider
//   pipelines of four stages each (tone rescale, then floor bias), the input
//   register, the bias product register and three classification stages.
// - The receiver cannot stall the block; results are only ever presented.
// - Configuration writes use cfg_we, cfg_addr and cfg_wdata and take effect
//   at once; write them only while no pixel is in flight.
// - Reset clears all valid bits and loads the register defaults; the block
//   accepts pixels in the first cycle after reset.
// ----------------------------------------------------------------------------
module threshold_screen_dot_classifier (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  tone,
	input  logic [7:0]  mask_value,
	input  logic [15:0] pixel_x,
	input  logic [15:0] pixel_y,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [7:0]  cfg_wdata,
	output logic        done,
	output logic [1:0]  dot_level,
	output logic [7:0]  effective_tone
);

	tsdc_pkg::cfg_t     cfg_q;
	logic [7:0]         thr;
	logic [7:0]         diff;

	logic               vld_s1;
	tsdc_pkg::sb_t      sb_s1;
	logic [15:0]        num_s1;
	logic [7:0]         den_s1;

	logic               div1_vld;
	logic [7:0]         eff;
	tsdc_pkg::sb_t      sba_s [tsdc_pkg::DIV_LAT];

	logic               bias_en;
	logic [7:0]         range_gap;
	logic               vld_s6;
	tsdc_pkg::bias_sb_t bsb_s6;
	logic [15:0]        num_s6;

	logic               div2_vld;
	logic [7:0]         bias;
	tsdc_pkg::bias_sb_t sbb_s [tsdc_pkg::DIV_LAT];

	logic [7:0]         hash;
	logic [7:0]         hd_s [tsdc_pkg::HASH_DELAY];

	tsdc_pkg::cls_in_t  cin;

	assign busy = 1'b0;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_ink     <= 8'd0;
			cfg_q.floor_range <= 8'd0;
			cfg_q.floor_max   <= 8'd0;
			cfg_q.small_base  <= tsdc_pkg::SMALL_CUT_LOW;
			cfg_q.medium_base <= tsdc_pkg::MEDIUM_CUT_LOW;
			cfg_q.swap_en     <= 1'b0;
			cfg_q.use_eff     <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				tsdc_pkg::REG_MIN_INK:     cfg_q.min_ink     <= cfg_wdata;
				tsdc_pkg::REG_FLOOR_RANGE: cfg_q.floor_range <= cfg_wdata;
				tsdc_pkg::REG_FLOOR_MAX:   cfg_q.floor_max   <= cfg_wdata;
				tsdc_pkg::REG_SMALL_BASE:  cfg_q.small_base  <= cfg_wdata;
				tsdc_pkg::REG_MEDIUM_BASE: cfg_q.medium_base <= cfg_wdata;
				tsdc_pkg::REG_SWAP_EN:     cfg_q.swap_en     <= cfg_wdata[0];
				tsdc_pkg::REG_USE_EFF:     cfg_q.use_eff     <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Clamp the threshold so the rescale divisor is never zero.
	always_comb begin
		thr  = (cfg_q.min_ink > tsdc_pkg::THR_MAX) ? tsdc_pkg::THR_MAX : cfg_q.min_ink;
		diff = tone - thr;
	end

	// Valid bits of the top level stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s6 <= div1_vld;
		end
	end

	// Stage 1: input register and rescale numerator, diff times 255.
	always_ff @(posedge clk) begin
		sb_s1.below <= tone <= thr;
		sb_s1.tone  <= tone;
		sb_s1.mask  <= mask_value;
		num_s1      <= {diff, 8'b0} - 16'(diff);
		den_s1      <= tsdc_pkg::FULL_TONE - thr;
	end

	tsdc_div u_div_rescale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s1),
		.num       (num_s1),
		.den       (den_s1),
		.out_valid (div1_vld),
		.quo       (eff)
	);

	// Pixel data alongside the rescale divider.
	always_ff @(posedge clk) begin
		sba_s[0] <= sb_s1;
		for (int i = 1; i < tsdc_pkg::DIV_LAT; i++) begin
			sba_s[i] <= sba_s[i-1];
		end
	end

	// Floor bias numerator: floor_max times the distance below floor_range.
	always_comb begin
		bias_en   = (cfg_q.floor_range != 8'd0) && (cfg_q.floor_max != 8'd0) &&
		            (eff < cfg_q.floor_range);
		range_gap = bias_en ? (cfg_q.floor_range - eff) : 8'd0;
	end

	always_ff @(posedge clk) begin
		bsb_s6.sb      <= sba_s[tsdc_pkg::DIV_LAT-1];
		bsb_s6.eff     <= eff;
		bsb_s6.bias_en <= bias_en;
		num_s6         <= 16'(cfg_q.floor_max) * 16'(range_gap);
	end

	tsdc_div u_div_bias (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s6),
		.num       (num_s6),
		.den       (cfg_q.floor_range),
		.out_valid (div2_vld),
		.quo       (bias)
	);

	// Pixel data alongside the bias divider.
	always_ff @(posedge clk) begin
		sbb_s[0] <= bsb_s6;
		for (int i = 1; i < tsdc_pkg::DIV_LAT; i++) begin
			sbb_s[i] <= sbb_s[i-1];
		end
	end

	tsdc_hash u_hash (
		.clk     (clk),
		.pixel_x (pixel_x),
		.pixel_y (pixel_y),
		.hash    (hash)
	);

	// Align the hash byte with the end of the bias divider.
	always_ff @(posedge clk) begin
		hd_s[0] <= hash;
		for (int i = 1; i < tsdc_pkg::HASH_DELAY; i++) begin
			hd_s[i] <= hd_s[i-1];
		end
	end

	always_comb begin
		cin.valid   = div2_vld;
		cin.below   = sbb_s[tsdc_pkg::DIV_LAT-1].sb.below;
		cin.tone    = sbb_s[tsdc_pkg::DIV_LAT-1].sb.tone;
		cin.mask    = sbb_s[tsdc_pkg::DIV_LAT-1].sb.mask;
		cin.eff     = sbb_s[tsdc_pkg::DIV_LAT-1].eff;
		cin.bias_en = sbb_s[tsdc_pkg::DIV_LAT-1].bias_en;
		cin.bias    = bias;
		cin.hash    = hd_s[tsdc_pkg::HASH_DELAY-1];
	end

	tsdc_class u_class (
		.clk            (clk),
		.arst_n         (arst_n),
		.cin            (cin),
		.cfg            (cfg_q),
		.done           (done),
		.dot_level      (dot_level),
		.effective_tone (effective_tone)
	);

	// Every transfer gives exactly one result.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##13 done)
		else $error("result missing for an accepted pixel");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 13))
		else $error("result without an accepted pixel");

	// An inked dot always carries a nonzero tone.
	a_dot_tone: assert property (@(posedge clk) disable iff (!arst_n)
		(done && dot_level != tsdc_pkg::DOT_NONE) |-> effective_tone != 8'd0)
		else $error("dot issued with zero tone");

	// Both dividers keep the same depth as their side data; this checks the bias divider.
	a_div_align: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s6 |-> ##(tsdc_pkg::DIV_LAT) div2_vld)
		else $error("bias divider out of step");

endmodule
